// File: rtl/core/bia_pkg.sv
// Shared types, codes and helpers for the bitmap index allocator.
package bia_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int INDEX_W   = 12;
    localparam int CFG_W     = 7;
    localparam int STATUS_W  = 2;

    localparam logic [CFG_W-1:0] CFG_RESET_WORDS = 7'd64;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    // Item held between the issue stage and the resolve stage
    typedef struct packed {
        logic             vld;
        logic             op;
        logic             oor;
        logic [BIT_W-1:0] bit_idx;
    } item_t;

    // Position of the lowest set bit; 63 when the word is empty
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: rtl/core/bia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bia_issue.sv
// Issue stage: word pointer, range check, bitmap read and item register.
module bia_issue #(
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [bia_pkg::CFG_W-1:0]                words_in_use,
    input  logic                                     req_valid,
    output logic                                     req_stall,
    input  logic                                     operation,
    input  logic [bia_pkg::INDEX_W-1:0]              release_index,
    input  logic                                     take,
    output bia_pkg::item_t                           item,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] item_addr,
    output logic                                     rd_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [bia_pkg::CFG_W-1:0] DEPTH_W = bia_pkg::CFG_W'(DEPTH);

    logic [AW-1:0]             ptr_reg;
    logic [AW-1:0]             ptr_next;
    bia_pkg::item_t            item_reg;
    bia_pkg::item_t            item_next;
    logic [AW-1:0]             addr_reg;
    logic [bia_pkg::CFG_W-1:0] n_eff;
    logic [7:0]                ptr8;
    logic [7:0]                cur8;
    logic [7:0]                nxt8;
    logic [11:0]               rel_word12;
    logic                      oor;
    logic                      accept;
    logic [AW-1:0]             addr;

    // Clamp the word count: zero acts as one, above the storage saturates
    always_comb
    begin
        if (words_in_use == '0)
        begin
            n_eff = bia_pkg::CFG_W'(1);
        end
        else if (words_in_use > DEPTH_W)
        begin
            n_eff = DEPTH_W;
        end
        else
        begin
            n_eff = words_in_use;
        end
    end

    always_comb
    begin
        ptr8 = 8'(ptr_reg);
        cur8 = (ptr8 >= 8'(n_eff)) ? 8'd0 : ptr8;
        nxt8 = cur8 + 8'd1;
        if (nxt8 >= 8'(n_eff))
        begin
            nxt8 = 8'd0;
        end
    end

    assign rel_word12 = {6'd0, release_index[11:6]};
    assign oor        = {1'b0, release_index} >= {n_eff, 6'd0};
    assign addr       = (operation == bia_pkg::OP_ALLOC) ? cur8[AW-1:0]
                                                         : rel_word12[AW-1:0];

    assign req_stall = item_reg.vld && !take;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        ptr_next  = ptr_reg;
        item_next = item_reg;
        if (accept)
        begin
            if (operation == bia_pkg::OP_ALLOC)
            begin
                ptr_next = nxt8[AW-1:0];
            end
            item_next.vld     = 1'b1;
            item_next.op      = operation;
            item_next.oor     = oor;
            item_next.bit_idx = release_index[bia_pkg::BIT_W-1:0];
        end
        else if (take)
        begin
            item_next.vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            item_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= addr;
        end
    end

    assign item      = item_reg;
    assign item_addr = addr_reg;
    assign rd_en     = accept;
    assign rd_addr   = addr;

endmodule

// File: rtl/core/bia_resolve.sv
// Resolve stage: forward, pick or set the bit, write back and hold the result.
module bia_resolve #(
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  bia_pkg::item_t                           item,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] item_addr,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [bia_pkg::WORD_BITS-1:0]            ram_q,
    output logic                                     take,
    output logic                                     wr_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    output logic [bia_pkg::WORD_BITS-1:0]            wr_data,
    output logic                                     rsp_valid,
    input  logic                                     rsp_stall,
    output logic [bia_pkg::INDEX_W-1:0]              granted_index,
    output logic [bia_pkg::STATUS_W-1:0]             status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0]                written_reg;
    logic                            rd_written_reg;
    logic                            byp_vld_reg;
    logic [AW-1:0]                   byp_addr_reg;
    logic [bia_pkg::WORD_BITS-1:0]   byp_data_reg;
    logic                            rsp_valid_reg;
    logic [bia_pkg::INDEX_W-1:0]     granted_reg;
    logic [bia_pkg::STATUS_W-1:0]    status_reg;
    logic [bia_pkg::WORD_BITS-1:0]   word;
    logic [bia_pkg::WORD_BITS-1:0]   new_word;
    logic [bia_pkg::BIT_W-1:0]       low_bit;
    logic [11:0]                     addr12;
    logic [bia_pkg::INDEX_W-1:0]     granted_next;
    logic [bia_pkg::STATUS_W-1:0]    status_next;
    logic                            changes;

    // An entry never written reads as all free; the last write overrides
    // the registered read when it hit the same word
    always_comb
    begin
        if (byp_vld_reg && (byp_addr_reg == item_addr))
        begin
            word = byp_data_reg;
        end
        else if (rd_written_reg)
        begin
            word = ram_q;
        end
        else
        begin
            word = '1;
        end
    end

    assign low_bit = bia_pkg::lowest_set(word);
    assign addr12  = 12'(item_addr);

    always_comb
    begin
        new_word     = word;
        granted_next = '0;
        status_next  = bia_pkg::ST_OK;
        changes      = 1'b0;
        if (item.op == bia_pkg::OP_ALLOC)
        begin
            if (word == '0)
            begin
                status_next = bia_pkg::ST_EXHAUSTED;
            end
            else
            begin
                new_word[low_bit] = 1'b0;
                granted_next      = {addr12[5:0], low_bit};
                changes           = 1'b1;
            end
        end
        else
        begin
            if (item.oor)
            begin
                status_next = bia_pkg::ST_RANGE;
            end
            else
            begin
                new_word[item.bit_idx] = 1'b1;
                changes                = 1'b1;
            end
        end
    end

    assign take    = item.vld && (!rsp_valid_reg || !rsp_stall);
    assign wr_en   = take && changes;
    assign wr_addr = item_addr;
    assign wr_data = new_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            byp_vld_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
            if (wr_en)
            begin
                written_reg[item_addr] <= 1'b1;
                byp_vld_reg            <= 1'b1;
            end
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= item_addr;
            byp_data_reg <= new_word;
        end
        if (take)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;

endmodule

// File: rtl/core/bitmap_index_allocator_unit.sv
// Bitmap index allocator: round-robin word pointer, lowest free bit per word.
// Accept registers item and bitmap read, take the result; one item per cycle
// unless the result is held. A one-entry write bypass covers back-to-back
// items on the same word, and the result register decouples the two channels.
// Reset: every index free (per-word written flags cleared), pointer at word 0,
// words_in_use at 64; no clearing pass, items are taken right after reset.
module bitmap_index_allocator_unit #(
    parameter int MAX_WORDS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bia_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                operation,
    input  logic [bia_pkg::INDEX_W-1:0]         release_index,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [bia_pkg::INDEX_W-1:0]         granted_index,
    output logic [bia_pkg::STATUS_W-1:0]        status
);

    // The 7-bit word count caps the usable words at 127, so storage
    // beyond that is never addressed.
    localparam int DEPTH = (MAX_WORDS < 127) ? MAX_WORDS : 127;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bia_pkg::CFG_W-1:0]      words_in_use_reg;
    bia_pkg::item_t                 item;
    logic [AW-1:0]                  item_addr;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [bia_pkg::WORD_BITS-1:0]  ram_q;
    logic                           take;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [bia_pkg::WORD_BITS-1:0]  wr_data;

    // Hold the word count; the user must write it only while idle (unchecked)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= bia_pkg::CFG_RESET_WORDS;
        end
        else if (cfg_wr_en)
        begin
            words_in_use_reg <= cfg_wr_data;
        end
    end

    // Stage 1: pick the word, advance the pointer, start the bitmap read
    bia_issue #(
        .DEPTH (DEPTH)
    ) u_issue (
        .clk           (clk),
        .rst_n         (rst_n),
        .words_in_use  (words_in_use_reg),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .release_index (release_index),
        .take          (take),
        .item          (item),
        .item_addr     (item_addr),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    // Free-bit bitmap, one 64-bit word per entry
    bia_ram #(
        .WIDTH (bia_pkg::WORD_BITS),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Stage 2: merge the bypass, clear or set the bit, write back, drive result
    bia_resolve #(
        .DEPTH (DEPTH)
    ) u_resolve (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_addr     (item_addr),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .ram_q         (ram_q),
        .take          (take),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_index (granted_index),
        .status        (status)
    );

`ifndef SYNTHESIS
    // Input backs up only when the result register is full and held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled without a held result");

    // Any failed item reports a zero index
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != bia_pkg::ST_OK)) |-> (granted_index == '0))
        else $error("failed item carries a nonzero index");

    // Bitmap writes only happen as a held item moves to the result
    a_write_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (take && item.vld))
        else $error("bitmap write without an advancing item");

    // An item that advances shows up as a valid result on the next cycle
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp_valid)
        else $error("advanced item did not produce a result");
`endif

endmodule

// File: test/tb_bitmap_index_allocator_unit.sv
// Self-checking testbench for the bitmap index allocator unit.
`timescale 1ns / 100ps

// One answer of the allocator: granted index and status code
typedef struct packed {
    logic [bia_pkg::INDEX_W-1:0]  index;
    logic [bia_pkg::STATUS_W-1:0] code;
} alloc_answer_t;

// Mirror of the free bitmap and the word pointer, plus the answers still owed
class alloc_scoreboard;
    logic [bia_pkg::WORD_BITS-1:0] free_map [64];
    int unsigned                   word_ptr;
    logic [bia_pkg::CFG_W-1:0]     word_count;
    alloc_answer_t                 pending_answers[$];
    logic [bia_pkg::INDEX_W-1:0]   held_indexes[$];
    int                            mismatches;

    function new();
        foreach (free_map[i])
            free_map[i] = '1;
        word_ptr   = 0;
        word_count = bia_pkg::CFG_RESET_WORDS;
        mismatches = 0;
    endfunction

    function void set_word_count(logic [bia_pkg::CFG_W-1:0] value);
        word_count = value;
    endfunction

    // Zero counts as one word, anything past the bitmap saturates
    function int unsigned usable_words();
        int unsigned n;
        n = word_count;
        if (n == 0)
            n = 1;
        if (n > 64)
            n = 64;
        return n;
    endfunction

    function int pending();
        return pending_answers.size();
    endfunction

    // Predict the answer to one accepted item and update the mirrored state
    function void note_request(logic op, logic [bia_pkg::INDEX_W-1:0] idx);
        int unsigned   n;
        int unsigned   w;
        int unsigned   b;
        alloc_answer_t ans;
        n         = usable_words();
        ans.index = '0;
        ans.code  = bia_pkg::ST_OK;
        if (op == bia_pkg::OP_ALLOC)
        begin
            w        = (word_ptr >= n) ? 0 : word_ptr;
            word_ptr = (w + 1 >= n) ? 0 : w + 1;
            if (free_map[w] == '0)
            begin
                ans.code = bia_pkg::ST_EXHAUSTED;
            end
            else
            begin
                b = 0;
                while (!free_map[w][b])
                    b++;
                free_map[w][b] = 1'b0;
                ans.index      = bia_pkg::INDEX_W'(w * bia_pkg::WORD_BITS + b);
                held_indexes.push_back(ans.index);
            end
        end
        else if (idx >= n * bia_pkg::WORD_BITS)
        begin
            ans.code = bia_pkg::ST_RANGE;
        end
        else
        begin
            free_map[idx[bia_pkg::INDEX_W-1:bia_pkg::BIT_W]][idx[bia_pkg::BIT_W-1:0]] = 1'b1;
        end
        pending_answers.push_back(ans);
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("mismatch %0d at %0t ns: %s", mismatches, $time, what);
    endtask

    task check_result(logic [bia_pkg::INDEX_W-1:0] index,
                      logic [bia_pkg::STATUS_W-1:0] code);
        alloc_answer_t want;
        if (pending_answers.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result index %0d status %0d", index, code));
        end
        else
        begin
            want = pending_answers.pop_front();
            if (index !== want.index)
                report_mismatch($sformatf("granted_index %0d, want %0d", index, want.index));
            if (code !== want.code)
                report_mismatch($sformatf("status %0d, want %0d", code, want.code));
        end
    endtask
endclass

module tb_bitmap_index_allocator_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;

    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [bia_pkg::CFG_W-1:0]    cfg_wr_data   = '0;
    logic                         req_valid     = 1'b0;
    logic                         req_stall;
    logic                         operation     = bia_pkg::OP_ALLOC;
    logic [bia_pkg::INDEX_W-1:0]  release_index = '0;
    logic                         rsp_valid;
    logic                         rsp_stall     = 1'b0;
    logic [bia_pkg::INDEX_W-1:0]  granted_index;
    logic [bia_pkg::STATUS_W-1:0] status;

    // Idle rates in percent; the schedule moves through three modes
    int req_idle_pct = 34;
    int rsp_idle_pct = 88;
    int items_sent   = 0;
    int cycle_count  = 0;

    alloc_scoreboard sb = new();

    // Word counts per random phase: extremes (0 and 127) included on purpose
    logic [bia_pkg::CFG_W-1:0] phase_words [PHASES] =
        '{7'd1, 7'd2, 7'd127, 7'd0, 7'd3, 7'd64};
    int                        phase_items [PHASES] = '{250, 200, 200, 150, 200, 150};

    bitmap_index_allocator_unit #(
        .MAX_WORDS (64)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .release_index (release_index),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_index (granted_index),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the slowest legal schedule is far exceeded
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Response side: check accepted results, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(granted_index, status);
        rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
    end

    // Present one item and hold it until the block takes it
    task automatic push_request(input logic op, input logic [bia_pkg::INDEX_W-1:0] idx);
        req_valid     <= 1'b1;
        operation     <= op;
        release_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(op, idx);
    endtask

    // Insert random sender gaps, send, then advance the idle schedule
    task automatic send_item(input logic op, input logic [bia_pkg::INDEX_W-1:0] idx);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        push_request(op, idx);
        items_sent++;
        if (items_sent == 400)
        begin
            req_idle_pct = 88;
            rsp_idle_pct = 34;
        end
        else if (items_sent == 800)
        begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
        end
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic drain_pending();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Every item answers, so an empty scoreboard means the block is idle
    task automatic write_word_count(input logic [bia_pkg::CFG_W-1:0] value);
        drain_pending();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_word_count(value);
    endtask

    // Mostly allocations, with releases of granted indexes to refill words;
    // the rest are arbitrary in-range and full-width releases
    task automatic pick_random_item(output logic op,
                                    output logic [bia_pkg::INDEX_W-1:0] idx);
        int r;
        int k;
        int unsigned n;
        r   = $urandom_range(0, 99);
        n   = sb.usable_words();
        op  = bia_pkg::OP_RELEASE;
        idx = bia_pkg::INDEX_W'($urandom_range(0, 4095));
        if (r < 65)
        begin
            op = bia_pkg::OP_ALLOC;
        end
        else if (r < 80 && sb.held_indexes.size() != 0)
        begin
            k   = $urandom_range(0, sb.held_indexes.size() - 1);
            idx = sb.held_indexes[k];
            sb.held_indexes.delete(k);
        end
        else if (r < 90)
        begin
            idx = bia_pkg::INDEX_W'($urandom_range(0, n * bia_pkg::WORD_BITS - 1));
        end
    endtask

    initial
    begin
        logic                        op;
        logic [bia_pkg::INDEX_W-1:0] idx;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fresh bitmap with the reset word count of 64
        send_item(bia_pkg::OP_ALLOC, 12'hFFF);
        send_item(bia_pkg::OP_ALLOC, 12'h000);
        send_item(bia_pkg::OP_RELEASE, 12'd0);
        // release an index that is already free: no effect, status ok
        send_item(bia_pkg::OP_RELEASE, 12'd0);
        send_item(bia_pkg::OP_RELEASE, 12'd4095);
        send_item(bia_pkg::OP_ALLOC, 12'h555);

        // Zero word count acts as one word; the pointer sits past it now,
        // so the next allocation must fall back to word 0
        write_word_count(7'd0);
        send_item(bia_pkg::OP_ALLOC, 12'hAAA);
        send_item(bia_pkg::OP_ALLOC, 12'd0);
        // out of range against a single word
        send_item(bia_pkg::OP_RELEASE, 12'd64);
        send_item(bia_pkg::OP_RELEASE, 12'd4095);
        send_item(bia_pkg::OP_RELEASE, 12'd63);

        // Oversized count saturates to the full bitmap
        write_word_count(7'd127);
        send_item(bia_pkg::OP_ALLOC, 12'd0);
        send_item(bia_pkg::OP_ALLOC, 12'd0);
        send_item(bia_pkg::OP_RELEASE, 12'd4095);
        send_item(bia_pkg::OP_RELEASE, 12'd2048);
        send_item(bia_pkg::OP_RELEASE, 12'd64);

        // Random phases, one word count each; pause once mid-phase until empty
        for (int p = 0; p < PHASES; p++)
        begin
            write_word_count(phase_words[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (i == phase_items[p] / 2)
                    drain_pending();
                pick_random_item(op, idx);
                send_item(op, idx);
            end
        end

        drain_pending();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
